@@ src/blwt_pkg.sv @@
// Shared types and constants for the board line-window tracker.
// No dependencies; imported by board_line_window_tracker_core.
package blwt_pkg;

  localparam int BOARD_MAX_DEF       = 32;
  localparam int WINDOW_HALF_MAX_DEF = 5;

  // field widths on the stream ports
  localparam int FUNC_W   = 2;
  localparam int COORD_IN = 5;
  localparam int STONE_W  = 2;
  localparam int DIR_W    = 2;
  localparam int WIN_W    = 22;
  localparam int STAT_W   = 2;
  localparam int IN_W     = FUNC_W + 2 * COORD_IN + STONE_W + DIR_W;  // 16
  localparam int OUT_W    = WIN_W + STAT_W;                           // 24

  // configuration register widths and reset values
  localparam int HALF_W   = 3;
  localparam int SIZE_W   = 6;
  localparam int CFG_W    = 6;
  localparam logic [HALF_W-1:0] HALF_RST = 3'd5;
  localparam logic [SIZE_W-1:0] ROWS_RST = 6'd15;
  localparam logic [SIZE_W-1:0] COLS_RST = 6'd15;

  // signed working width for offset coordinates and board limits
  localparam int COORD_W  = 8;
  localparam int K_W      = 4;
  localparam int OFF_W    = 5;

  typedef enum logic [1:0] {
    CFG_WINDOW_HALF = 2'd0,
    CFG_BOARD_ROWS  = 2'd1,
    CFG_BOARD_COLS  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PLACE  = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORZ = 2'd0,
    DIR_VERT = 2'd1,
    DIR_DIAG = 2'd2,
    DIR_ANTI = 2'd3
  } dir_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_STONE = 2'd3
  } status_t;

  localparam logic [1:0] CELL_EMPTY  = 2'd0;
  localparam logic [1:0] CELL_CROSS  = 2'd1;
  localparam logic [1:0] CELL_CIRCLE = 2'd2;
  localparam logic [1:0] CELL_OFF    = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WIN_ISSUE,
    S_WIN_COLLECT,
    S_CELL_CHECK,
    S_DONE
  } state_t;

endpackage

@@ src/board_line_window_tracker_core.sv @@
// Board line-window tracker: grid store, sequencer and stream ports.
// Depends on blwt_pkg (types, codes, widths).
// One item at a time: the next beat is taken once the result is loaded into
//   the output register.
// Reset: synchronous, active low; a clearing pass (one row per cycle)
//   follows, during which in_tready stays low. Config writes work.
module board_line_window_tracker_core
  import blwt_pkg::*;
#(
  parameter int BOARD_MAX       = BOARD_MAX_DEF,
  parameter int WINDOW_HALF_MAX = WINDOW_HALF_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: func[1:0], row[6:2], col[11:7], stone[13:12], direction[15:14]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // out_tdata: window[21:0], status[23:22]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW    = (BOARD_MAX > 1) ? $clog2(BOARD_MAX) : 1;
  localparam int ROW_W = 2 * BOARD_MAX;

  // ---------------------------------------------------------------------------
  // Board store: one memory row holds a whole board row, two bits per cell.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] board_mem [BOARD_MAX];
  logic [ROW_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      board_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= board_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [HALF_W-1:0] window_half_r;
  logic [SIZE_W-1:0] board_rows_r;
  logic [SIZE_W-1:0] board_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_half_r <= HALF_RST;
      board_rows_r  <= ROWS_RST;
      board_cols_r  <= COLS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_HALF: window_half_r <= cfg_wdata[HALF_W-1:0];
        CFG_BOARD_ROWS:  board_rows_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_BOARD_COLS:  board_cols_r  <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits: oversize sizes clamp to the store size, the half width to WINDOW_HALF_MAX
  logic signed [COORD_W-1:0] lim_rows, lim_cols;
  logic [HALF_W-1:0]         half_eff;
  logic [K_W-1:0]            k_last;

  always_comb begin
    lim_rows = (COORD_W'(board_rows_r) > COORD_W'(BOARD_MAX)) ?
               COORD_W'(BOARD_MAX) : COORD_W'(board_rows_r);
    lim_cols = (COORD_W'(board_cols_r) > COORD_W'(BOARD_MAX)) ?
               COORD_W'(BOARD_MAX) : COORD_W'(board_cols_r);
    half_eff = (window_half_r > HALF_W'(WINDOW_HALF_MAX)) ?
               HALF_W'(WINDOW_HALF_MAX) : window_half_r;
    k_last   = {half_eff, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Item registers
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [FUNC_W-1:0]    func_r;
  logic [COORD_IN-1:0]  row_r, col_r;
  logic [STONE_W-1:0]   stone_r;
  logic [DIR_W-1:0]     dir_r;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [WIN_W-1:0]     window_r, window_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [AW-1:0]        col_idx_r, col_idx_nxt;
  logic                 off_r, off_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 clr_item_r, clr_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic in_beat;
  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Shared coordinate unit: centre plus offset, checked against the limits.
  // Used once per window position, and with zero offset for the centre cell.
  // ---------------------------------------------------------------------------
  logic signed [OFF_W-1:0]   off_d, off_dr, off_dc;
  logic signed [COORD_W-1:0] cr, cc;
  logic                      c_inb;
  logic [AW-1:0]             cr_idx, cc_idx;
  logic                      centre_sel;

  assign centre_sel = (state_r == S_DECODE);

  always_comb begin
    off_d  = OFF_W'(signed'({1'b0, k_r})) - OFF_W'(signed'({1'b0, half_eff}));
    off_dr = '0;
    off_dc = '0;
    if (!centre_sel) begin
      case (dir_t'(dir_r))
        DIR_HORZ: off_dc = off_d;
        DIR_VERT: off_dr = off_d;
        DIR_DIAG: begin
          off_dr = off_d;
          off_dc = off_d;
        end
        DIR_ANTI: begin
          off_dr = -off_d;
          off_dc = off_d;
        end
        default: ;
      endcase
    end
    cr     = COORD_W'(signed'({1'b0, row_r})) + COORD_W'(off_dr);
    cc     = COORD_W'(signed'({1'b0, col_r})) + COORD_W'(off_dc);
    c_inb  = (cr >= 0) && (cr < lim_rows) && (cc >= 0) && (cc < lim_cols);
    cr_idx = cr[AW-1:0];
    cc_idx = cc[AW-1:0];
  end

  // cell picked out of the registered row
  logic [1:0]       cell_rd;
  logic [1:0]       cell_val;
  logic [ROW_W-1:0] row_mod;
  logic [1:0]       new_cell;

  always_comb begin
    cell_rd  = rd_data_r[{col_idx_r, 1'b0} +: 2];
    cell_val = off_r ? CELL_OFF : cell_rd;
    new_cell = (func_t'(func_r) == FN_PLACE) ? stone_r : CELL_EMPTY;
    row_mod  = rd_data_r;
    row_mod[{col_idx_r, 1'b0} +: 2] = new_cell;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(BOARD_MAX - 1)) begin
          state_nxt = clr_item_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (func_t'(func_r) == FN_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (!c_inb) begin
          state_nxt = S_DONE;
        end else if (func_t'(func_r) == FN_READ) begin
          state_nxt = S_WIN_ISSUE;
        end else if (stone_r != CELL_CROSS && stone_r != CELL_CIRCLE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CELL_CHECK;
        end
      end
      S_WIN_ISSUE:   state_nxt = S_WIN_COLLECT;
      S_WIN_COLLECT: state_nxt = (k_r == k_last) ? S_DONE : S_WIN_ISSUE;
      S_CELL_CHECK:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and store controls
  // ---------------------------------------------------------------------------
  always_comb begin
    k_nxt         = k_r;
    window_nxt    = window_r;
    status_nxt    = status_r;
    col_idx_nxt   = col_idx_r;
    off_nxt       = off_r;
    clr_addr_nxt  = clr_addr_r;
    clr_item_nxt  = clr_item_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr       = cr_idx;
    wr_en         = 1'b0;
    wr_addr       = clr_addr_r;
    wr_data       = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(BOARD_MAX - 1)) clr_addr_nxt = '0;
      end
      S_DECODE: begin
        // centre row read goes out now; place/remove check it next cycle
        k_nxt       = '0;
        window_nxt  = '0;
        col_idx_nxt = cc_idx;
        off_nxt     = 1'b0;
        status_nxt  = STAT_OK;
        if (func_t'(func_r) == FN_CLEAR) begin
          clr_item_nxt = 1'b1;
        end else if (!c_inb) begin
          status_nxt = STAT_RANGE;
        end else if (func_t'(func_r) != FN_READ &&
                     stone_r != CELL_CROSS && stone_r != CELL_CIRCLE) begin
          status_nxt = STAT_STONE;
        end
      end
      S_WIN_ISSUE: begin
        col_idx_nxt = cc_idx;
        off_nxt     = !c_inb;
      end
      S_WIN_COLLECT: begin
        window_nxt[{k_r, 1'b0} +: 2] = cell_val;
        k_nxt = k_r + K_W'(1);
      end
      S_CELL_CHECK: begin
        wr_addr = AW'(row_r);
        wr_data = row_mod;
        if (func_t'(func_r) == FN_PLACE) begin
          if (cell_rd != CELL_EMPTY) status_nxt = STAT_BUSY;
          else                       wr_en = 1'b1;
        end else begin
          if (cell_rd != stone_r) status_nxt = STAT_BUSY;
          else                    wr_en = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {status_r, window_r};
          clr_item_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r  <= in_tdata[1:0];
      row_r   <= in_tdata[6:2];
      col_r   <= in_tdata[11:7];
      stone_r <= in_tdata[13:12];
      dir_r   <= in_tdata[15:14];
    end
    k_r        <= k_nxt;
    window_r   <= window_nxt;
    status_r   <= status_nxt;
    col_idx_r  <= col_idx_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for board_line_window_tracker_core: directed and random
// board moves, scored against an in-bench grid model. Needs blwt_pkg.
`timescale 1ns / 1ps

module testbench;
  import blwt_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int HOLD_CYCLES = 300;        // long receiver hold-off, fills the block
  localparam int TAIL_CYCLES = 40;         // tail wait; the slowest item is a clear
  localparam int TIMEOUT_NS  = 600_000 * CLK_PERIOD;

  // one result beat as the scoreboard sees it
  typedef struct packed {
    logic [WIN_W-1:0] window;
    status_t          status;
  } verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // in_tdata: func, row, col, stone, direction (lowest bits first)
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  // out_tdata: window, status (lowest bits first)
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en  = 1'b0;
  logic [1:0]        cfg_index  = '0;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  // bench copy of the block's state
  logic [1:0]        grid_copy [BOARD_MAX_DEF][BOARD_MAX_DEF];
  logic [HALF_W-1:0] half_cfg = HALF_RST;
  logic [SIZE_W-1:0] rows_cfg = ROWS_RST;
  logic [SIZE_W-1:0] cols_cfg = COLS_RST;

  verdict_t awaited_verdicts [$];
  int       fail_count    = 0;
  int       send_idle_pct = 13;
  int       recv_idle_pct = 65;
  int       hold_requests = 0;   // bumped by stimulus only
  int       hold_served   = 0;   // receiver side bookkeeping
  int       hold_left     = 0;

  board_line_window_tracker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void wipe_grid();
    foreach (grid_copy[r, c]) grid_copy[r][c] = CELL_EMPTY;
  endfunction

  // Works out the result of one accepted beat and updates the grid copy.
  // Oversized registers saturate; cells off the board in use read as CELL_OFF.
  function automatic verdict_t apply_move(input func_t fn, input logic [COORD_IN-1:0] r,
                                          input logic [COORD_IN-1:0] c,
                                          input logic [STONE_W-1:0] st, input dir_t dr);
    verdict_t   v;
    int         h, lr, lc, ri, ci, dd, rr, cc;
    logic [1:0] cell_code;
    v.window = '0;
    v.status = STAT_OK;
    h  = (half_cfg > WINDOW_HALF_MAX_DEF) ? WINDOW_HALF_MAX_DEF : int'(half_cfg);
    lr = (rows_cfg > BOARD_MAX_DEF) ? BOARD_MAX_DEF : int'(rows_cfg);
    lc = (cols_cfg > BOARD_MAX_DEF) ? BOARD_MAX_DEF : int'(cols_cfg);
    ri = int'(r);
    ci = int'(c);
    if (fn == FN_CLEAR) begin
      wipe_grid();
    end else if (ri >= lr || ci >= lc) begin
      v.status = STAT_RANGE;
    end else if (fn == FN_READ) begin
      for (int k = 0; k <= 2 * h; k++) begin
        dd = k - h;
        case (dr)
          DIR_HORZ: begin rr = ri;      cc = ci + dd; end
          DIR_VERT: begin rr = ri + dd; cc = ci;      end
          DIR_DIAG: begin rr = ri + dd; cc = ci + dd; end
          default:  begin rr = ri - dd; cc = ci + dd; end
        endcase
        if (rr < 0 || cc < 0 || rr >= lr || cc >= lc) cell_code = CELL_OFF;
        else cell_code = grid_copy[rr][cc];
        v.window[2*k +: 2] = cell_code;
      end
    end else if (st != CELL_CROSS && st != CELL_CIRCLE) begin
      v.status = STAT_STONE;
    end else if (fn == FN_PLACE) begin
      if (grid_copy[ri][ci] != CELL_EMPTY) v.status = STAT_BUSY;
      else grid_copy[ri][ci] = st;
    end else begin
      if (grid_copy[ri][ci] != st) v.status = STAT_BUSY;
      else grid_copy[ri][ci] = CELL_EMPTY;
    end
    return v;
  endfunction

  // Offers one beat, with random idle gaps first; predicts on acceptance.
  // Leaves tvalid high on return, so back-to-back beats keep it asserted.
  task automatic send_move(input func_t fn, input logic [COORD_IN-1:0] r,
                           input logic [COORD_IN-1:0] c, input logic [STONE_W-1:0] st,
                           input dir_t dr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dr, st, c, r, fn};
    do @(posedge clk); while (!in_tready);
    awaited_verdicts.push_back(apply_move(fn, r, c, st, dr));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  // Block is idle once every result is back; then all registers are written,
  // plus the spare index, which must be ignored.
  task automatic set_board(input int half, input int rows, input int cols);
    logic [CFG_W-1:0] junk;
    drain_results();
    for (int i = 0; i < 4; i++) begin
      junk = CFG_W'($urandom);
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      case (cfg_idx_t'(i))
        CFG_WINDOW_HALF: cfg_wdata <= {junk[CFG_W-1:HALF_W], half[HALF_W-1:0]};
        CFG_BOARD_ROWS:  cfg_wdata <= rows[SIZE_W-1:0];
        CFG_BOARD_COLS:  cfg_wdata <= cols[SIZE_W-1:0];
        default:         cfg_wdata <= junk;
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    half_cfg = half[HALF_W-1:0];
    rows_cfg = rows[SIZE_W-1:0];
    cols_cfg = cols[SIZE_W-1:0];
  endtask

  // Receiver: random stalls, plus an occasional long hold-off on request.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: each result beat against the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    logic [WIN_W-1:0] got_win;
    logic [STAT_W-1:0] got_stat;
    if (rst_n && out_tvalid && out_tready) begin
      got_win  = out_tdata[WIN_W-1:0];
      got_stat = out_tdata[OUT_W-1:WIN_W];
      if (awaited_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result beat with nothing pending: window %h status %0d",
                   $realtime, got_win, got_stat);
      end else begin
        want = awaited_verdicts.pop_front();
        if (got_win !== want.window || got_stat !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: expected window %h status %0d, got window %h status %0d",
                     $realtime, want.window, want.status, got_win, got_stat);
        end
      end
    end
  end

  // Reset defaults: empty 15x15 board, half width 5; edges read off-board.
  task automatic test_empty_board_reads();
    send_move(FN_READ, 5'd7, 5'd7, CELL_EMPTY, DIR_HORZ);
    send_move(FN_READ, 5'd0, 5'd0, CELL_OFF, DIR_DIAG);
    send_move(FN_READ, 5'd14, 5'd14, CELL_CROSS, DIR_ANTI);
    send_move(FN_READ, 5'd15, 5'd3, CELL_EMPTY, DIR_VERT);     // row just off board
    send_move(FN_READ, 5'd31, 5'd31, CELL_OFF, DIR_ANTI);
  endtask

  // Place/remove rules: occupancy, colour mismatch, bad stones, error order.
  task automatic test_stone_rules();
    send_move(FN_PLACE, 5'd7, 5'd7, CELL_CROSS, DIR_ANTI);
    send_move(FN_PLACE, 5'd7, 5'd7, CELL_CIRCLE, DIR_HORZ);    // occupied
    send_move(FN_REMOVE, 5'd7, 5'd7, CELL_CIRCLE, DIR_HORZ);   // wrong colour
    send_move(FN_PLACE, 5'd8, 5'd8, CELL_CIRCLE, DIR_VERT);
    send_move(FN_PLACE, 5'd6, 5'd8, CELL_CROSS, DIR_DIAG);
    send_move(FN_READ, 5'd7, 5'd7, CELL_CIRCLE, DIR_DIAG);
    send_move(FN_READ, 5'd7, 5'd7, CELL_EMPTY, DIR_ANTI);
    send_move(FN_PLACE, 5'd7, 5'd7, CELL_EMPTY, DIR_HORZ);     // stone code invalid beats busy
    send_move(FN_REMOVE, 5'd7, 5'd7, CELL_OFF, DIR_HORZ);
    send_move(FN_PLACE, 5'd3, 5'd15, CELL_EMPTY, DIR_HORZ);    // range beats stone
    send_move(FN_REMOVE, 5'd7, 5'd7, CELL_CROSS, DIR_HORZ);
    send_move(FN_REMOVE, 5'd7, 5'd7, CELL_CROSS, DIR_HORZ);    // already empty
  endtask

  task automatic test_clear_board();
    send_move(FN_CLEAR, 5'd31, 5'd31, CELL_OFF, DIR_ANTI);     // fields ignored
    send_move(FN_READ, 5'd8, 5'd8, CELL_OFF, DIR_HORZ);
  endtask

  // Register extremes: tiny and oversized boards, zero and oversized half,
  // and stones kept while the board shrinks then grows again.
  task automatic test_register_extremes();
    set_board(0, 1, 1);
    send_move(FN_PLACE, 5'd0, 5'd0, CELL_CIRCLE, DIR_HORZ);
    send_move(FN_READ, 5'd0, 5'd0, CELL_EMPTY, DIR_VERT);
    send_move(FN_READ, 5'd0, 5'd1, CELL_EMPTY, DIR_HORZ);
    set_board(7, 63, 63);
    send_move(FN_PLACE, 5'd31, 5'd31, CELL_CROSS, DIR_HORZ);
    send_move(FN_READ, 5'd31, 5'd31, CELL_EMPTY, DIR_VERT);
    set_board(4, 0, 0);
    send_move(FN_READ, 5'd0, 5'd0, CELL_EMPTY, DIR_HORZ);
    set_board(5, 32, 32);
    send_move(FN_READ, 5'd28, 5'd28, CELL_EMPTY, DIR_DIAG);
    set_board(5, 30, 30);
    send_move(FN_READ, 5'd28, 5'd28, CELL_EMPTY, DIR_DIAG);
    set_board(5, 32, 32);
    send_move(FN_READ, 5'd28, 5'd28, CELL_EMPTY, DIR_DIAG);  // stone back in view
    send_move(FN_CLEAR, 5'd0, 5'd0, CELL_EMPTY, DIR_HORZ);
  endtask

  // Mostly legal play on random board shapes; some beats fully random.
  task automatic test_random_play(input int first_plan, input int n_plans,
                                  input int per_plan, input bit with_hold);
    int                   plan [12][3];
    int                   lr, lc, pick;
    func_t                fn;
    logic [COORD_IN-1:0]  r, c;
    logic [STONE_W-1:0]   st;
    plan = '{'{5, 15, 15}, '{4, 19, 19}, '{5, 32, 32}, '{3, 7, 9},
             '{7, 63, 40}, '{0, 6, 6},   '{4, 11, 5},  '{2, 32, 1},
             '{1, 1, 32},  '{6, 5, 20},  '{5, 15, 15}, '{4, 33, 2}};
    for (int p = first_plan; p < first_plan + n_plans; p++) begin
      set_board(plan[p][0], plan[p][1], plan[p][2]);
      lr = (rows_cfg > BOARD_MAX_DEF) ? BOARD_MAX_DEF : int'(rows_cfg);
      lc = (cols_cfg > BOARD_MAX_DEF) ? BOARD_MAX_DEF : int'(cols_cfg);
      for (int n = 0; n < per_plan; n++) begin
        if (with_hold && p == first_plan && n == per_plan / 2)
          hold_requests <= hold_requests + 1;
        pick = $urandom_range(99);
        r = ($urandom_range(99) < 90) ? COORD_IN'($urandom_range(lr - 1))
                                      : COORD_IN'($urandom);
        c = ($urandom_range(99) < 90) ? COORD_IN'($urandom_range(lc - 1))
                                      : COORD_IN'($urandom);
        st = ($urandom_range(1) == 1) ? CELL_CROSS : CELL_CIRCLE;
        if (pick < 38) begin
          fn = FN_PLACE;
        end else if (pick < 62) begin
          fn = FN_REMOVE;
          // usually remove what is really there
          if (r < lr && c < lc && grid_copy[r][c] != CELL_EMPTY && $urandom_range(99) < 80)
            st = grid_copy[r][c];
        end else if (pick < 91) begin
          fn = FN_READ;
        end else if (pick < 93) begin
          fn = FN_CLEAR;
        end else begin
          fn = func_t'($urandom_range(3));
          st = STONE_W'($urandom);
        end
        send_move(fn, r, c, st, dir_t'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    wipe_grid();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_board_reads();
    test_stone_rules();
    test_clear_board();
    test_register_extremes();

    // sender idles lightly, receiver heavily; long hold-off in here
    test_random_play(0, 4, 121, 1'b1);
    drain_results();
    send_idle_pct = 65;
    recv_idle_pct = 13;
    test_random_play(4, 4, 121, 1'b0);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_play(8, 4, 121, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
